// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker of the search and replace block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/ssr_pkg.sv =====
// Types and constants shared by the search and replace block.
`default_nettype none

package ssr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int REPLACE_MAX_DEF = 8;
	localparam int BYTE_W          = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 8;
	localparam int LEN_W           = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 8'd0,
		REG_PATTERN_LENGTH     = 8'd1,
		REG_REPLACEMENT_BYTES  = 8'd2,
		REG_REPLACEMENT_LENGTH = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_BYTE,
		EM_REPL,
		EM_FLUSH
	} em_state_t;

	// Work handed from the window to the result sequencer for one item.
	typedef struct packed {
		logic              has_byte;
		logic [BYTE_W-1:0] byte_val;
		logic              do_repl;
		logic              flush;
	} job_t;

	typedef struct packed {
		logic [BYTE_W-1:0] head;
		logic              empty;
	} win_stat_t;

	typedef struct packed {
		logic take;
		logic pop;
	} emit_stat_t;

	typedef struct packed {
		logic shift;
		logic wr;
		logic stored;
		logic used;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssr_if.sv =====
// Handshake channel interfaces: text input, result output and register writes.
`default_nettype none

interface ssr_in_if;
	import ssr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              byte_present;
	logic              ends_line;

	modport source (output valid, output text_byte, output byte_present, output ends_line,
		input ready);
	modport sink (input valid, input text_byte, input byte_present, input ends_line,
		output ready);
endinterface

interface ssr_out_if;
	import ssr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_byte_present;
	logic              line_done;
	logic              last_of_run;

	modport source (output valid, output out_byte, output out_byte_present,
		output line_done, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input out_byte_present,
		input line_done, input last_of_run, output ready);
endinterface

interface ssr_cfg_if;
	import ssr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssr_cell.sv =====
// One window cell: holds a pending byte, shifts towards the head, compares with its pattern lane.
`default_nettype none

module ssr_cell import ssr_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [BYTE_W-1:0] nbr_byte,
	input  logic [BYTE_W-1:0] pat_byte,
	input  logic              match_in,
	output logic [BYTE_W-1:0] byte_out,
	output logic              match_out
);

	logic [BYTE_W-1:0] byte_q;
	logic              local_ok;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			byte_q <= in_byte;
		end else if (ctl.shift) begin
			byte_q <= nbr_byte;
		end
	end

	// A lane past the pattern always agrees; a used lane above the stored bytes sees the new one.
	always_comb begin
		if (!ctl.used) begin
			local_ok = 1'b1;
		end else if (ctl.stored) begin
			local_ok = (byte_q == pat_byte);
		end else begin
			local_ok = (in_byte == pat_byte);
		end
	end

	assign match_out = match_in & local_ok;
	assign byte_out  = byte_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_emit.sv =====
// Result sequencer: puts one item's results, one per unstalled cycle, into the output register.
`default_nettype none

module ssr_emit import ssr_pkg::*; #(
	parameter int REPLACE_MAX = REPLACE_MAX_DEF,
	localparam int RLW = $clog2(REPLACE_MAX + 1),
	localparam int IW  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  job_t                  job,
	input  logic [CFG_DATA_W-1:0] rep_bytes,
	input  logic [RLW-1:0]        rep_len,
	input  win_stat_t             win,
	output emit_stat_t            stat,
	ssr_out_if.source             result
);

	em_state_t         state_q, state_d, state_n;
	logic [IW-1:0]     idx_q, idx_d, idx_n;
	logic [BYTE_W-1:0] byte_q;
	logic              flush_q;

	logic [BYTE_W-1:0] lane [REPLACE_MAX];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_present_q;
	logic              out_done_q;
	logic              out_last_q;

	logic              slot_free;
	logic              emit;
	logic [BYTE_W-1:0] e_byte;
	logic              e_present;
	logic              e_done;
	logic              e_last;
	logic              pop;
	logic              take;
	logic              rep_end;

	for (genvar i = 0; i < REPLACE_MAX; i++) begin : g_lane
		assign lane[i] = rep_bytes[i*BYTE_W +: BYTE_W];
	end

	assign slot_free = !out_valid_q || result.ready;
	assign rep_end   = ((RLW'(idx_q) + RLW'(1)) == rep_len);

	always_comb begin
		state_n   = state_q;
		idx_n     = idx_q;
		emit      = 1'b0;
		e_byte    = '0;
		e_present = 1'b1;
		e_done    = 1'b0;
		e_last    = 1'b0;
		pop       = 1'b0;
		case (state_q)
			EM_IDLE: begin
			end
			EM_BYTE: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_byte  = byte_q;
					e_last  = !flush_q;
					state_n = flush_q ? EM_FLUSH : EM_IDLE;
				end
			end
			EM_REPL: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_byte = lane[idx_q];
					if (rep_end) begin
						e_last  = !flush_q;
						idx_n   = '0;
						state_n = flush_q ? EM_FLUSH : EM_IDLE;
					end else begin
						idx_n = idx_q + IW'(1);
					end
				end
			end
			EM_FLUSH: begin
				if (slot_free) begin
					emit = 1'b1;
					if (!win.empty) begin
						e_byte = win.head;
						pop    = 1'b1;
					end else begin
						// window drained: close the line
						e_present = 1'b0;
						e_done    = 1'b1;
						e_last    = 1'b1;
						state_n   = EM_IDLE;
					end
				end
			end
			default: begin
				state_n = EM_IDLE;
			end
		endcase

		take = (state_q == EM_IDLE) || (emit && (state_n == EM_IDLE));
	end

	// a new job overrides whatever the current one would do next
	always_comb begin
		state_d = state_n;
		idx_d   = idx_n;
		if (load) begin
			idx_d = '0;
			if (job.has_byte) begin
				state_d = EM_BYTE;
			end else if (job.do_repl) begin
				state_d = EM_REPL;
			end else begin
				state_d = EM_FLUSH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= job.byte_val;
			flush_q <= job.flush;
		end
		if (slot_free && emit) begin
			out_byte_q    <= e_byte;
			out_present_q <= e_present;
			out_done_q    <= e_done;
			out_last_q    <= e_last;
		end
	end

	assign stat.take = take;
	assign stat.pop  = pop;

	assign result.valid            = out_valid_q;
	assign result.out_byte         = out_byte_q;
	assign result.out_byte_present = out_present_q;
	assign result.line_done        = out_done_q;
	assign result.last_of_run      = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/substring_search_replace.sv =====
// Streaming search and replace: top level with registers, window cell row and result sequencer.
//
// Channels: text takes one item per transfer (a byte, a line end, or both); result
// gives one output item per transfer; cfg writes register index 0..3 (pattern bytes,
// pattern length, replacement bytes, replacement length), always ready, and is to be
// used only while the block is idle. Writing the pattern length empties the window.
// An item goes into the sequencer state, then its first result into the output register.
// Throughput: one item per cycle while each item gives at most one result and result.ready
// is high. An item giving several results holds text.ready low until its last result is
// out, a line end until each pending byte and the marker are out. The figure is set by the
// result sequencer, which puts at most one result per cycle into the single output register.
// Reset: registers go to zero (pass-through), the window is empty, nothing is offered.
// Stall: the output register holds its item while result.ready is low; one further
// item with results is taken into the sequencer, after which text.ready stays low
// until the sequencer can finish it.
`default_nettype none

module substring_search_replace import ssr_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssr_in_if.sink    text,
	ssr_out_if.source result,
	ssr_cfg_if.sink   cfg
);

	localparam int CW  = $clog2(PATTERN_MAX + 1);
	localparam int RLW = $clog2(REPLACE_MAX + 1);

	logic [CFG_DATA_W-1:0] pat_bytes_q;
	logic [LEN_W-1:0]      pat_len_q;
	logic [CFG_DATA_W-1:0] rep_bytes_q;
	logic [LEN_W-1:0]      rep_len_q;

	logic [CW-1:0]  plen;
	logic [RLW-1:0] rlen;
	logic [CW-1:0]  count_q;

	logic [BYTE_W-1:0] cell_byte [PATTERN_MAX];
	logic              chain [PATTERN_MAX+1];
	cell_ctl_t         ctl [PATTERN_MAX];

	logic       cfg_wr;
	logic       plen_wr;
	logic       acc;
	logic       thru;
	logic       full;
	logic       pushing;
	logic       hit;
	logic       miss;
	logic       load;
	job_t       job;
	win_stat_t  win;
	emit_stat_t est;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign plen_wr   = cfg_wr && (cfg.index == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= '0;
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_PATTERN_BYTES:      pat_bytes_q <= cfg.data;
				REG_PATTERN_LENGTH:     pat_len_q   <= cfg.data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg.data;
				REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg.data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp oversized lengths
	assign plen = (pat_len_q > LEN_W'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : pat_len_q[CW-1:0];
	assign rlen = (rep_len_q > LEN_W'(REPLACE_MAX)) ? RLW'(REPLACE_MAX) : rep_len_q[RLW-1:0];

	assign text.ready = est.take;
	assign acc        = text.valid && text.ready;
	assign thru       = (plen == '0);
	assign full       = ((count_q + CW'(1)) >= plen);
	assign pushing    = acc && text.byte_present && !thru;
	assign hit        = pushing && full && chain[0];
	assign miss       = pushing && full && !chain[0];

	always_comb begin
		job.has_byte = text.byte_present && (thru || (full && !chain[0]));
		job.byte_val = (thru || (count_q == '0)) ? text.text_byte : cell_byte[0];
		job.do_repl  = text.byte_present && !thru && full && chain[0] && (rlen != '0);
		job.flush    = text.ends_line;
	end

	assign load = acc && (job.has_byte || job.do_repl || job.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (plen_wr) begin
			count_q <= '0;
		end else if (hit) begin
			count_q <= '0;
		end else if (pushing && !full) begin
			count_q <= count_q + CW'(1);
		end else if (est.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign chain[PATTERN_MAX] = 1'b1;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [BYTE_W-1:0] nbr;

		if (i == PATTERN_MAX - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_body
			assign nbr = cell_byte[i+1];
		end

		// on a miss the new byte lands one place down, as the head leaves
		assign ctl[i].shift  = miss || est.pop;
		assign ctl[i].wr     = (pushing && !full && (count_q == CW'(i)))
			|| (miss && (count_q == CW'(i + 1)));
		assign ctl[i].stored = (CW'(i) < count_q);
		assign ctl[i].used   = (CW'(i) < plen);

		ssr_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.in_byte   (text.text_byte),
			.nbr_byte  (nbr),
			.pat_byte  (pat_bytes_q[i*BYTE_W +: BYTE_W]),
			.match_in  (chain[i+1]),
			.byte_out  (cell_byte[i]),
			.match_out (chain[i])
		);
	end

	assign win.head  = cell_byte[0];
	assign win.empty = (count_q == '0);

	ssr_emit #(
		.REPLACE_MAX (REPLACE_MAX)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.job       (job),
		.rep_bytes (rep_bytes_q),
		.rep_len   (rlen),
		.win       (win),
		.stat      (est),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_chk.sv =====
// Port-level checker for the search and replace block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ssr_chk import ssr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_present,
	input logic              out_line_done,
	input logic              out_last
);

	`SSR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_present) && $stable(out_line_done) && $stable(out_last), "result changed while stalled")
	`SSR_ASSERT_IMP(a_marker_form, out_valid && !out_present, out_line_done && out_last && (out_byte == '0), "malformed line marker")
	`SSR_ASSERT_IMP(a_done_no_byte, out_valid && out_line_done, !out_present, "line marker carries a byte")
	`SSR_ASSERT_NXT(a_busy_offers, !in_ready, out_valid, "input held off with nothing offered")

endmodule

bind substring_search_replace ssr_chk u_ssr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (text.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_byte      (result.out_byte),
	.out_present   (result.out_byte_present),
	.out_line_done (result.line_done),
	.out_last      (result.last_of_run)
);

`default_nettype wire
